>>> hdl/glpd_pkg.sv
// glpd_pkg: shared types and constants of the grid local peak detector
// used by the core top level, the window scan and the result emitter; no dependencies
`default_nettype none

package glpd_pkg;

  // configuration register indexes and widths
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_ROWS_W  = 11;
  localparam int CFG_COLS_W  = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_ROWS = 2'd0,
    REG_FRAME_COLS = 2'd1
  } glpd_reg_e;

  // result fields on the master side
  localparam int ROW_OUT_W   = 10;
  localparam int COL_OUT_W   = 5;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = OUT_TDATA_W - ROW_OUT_W - COL_OUT_W;

  // hand-over from the window scan to the result emitter
  typedef struct packed {
    logic load;   // one evaluated sample
    logic above;  // peak in the row above at the sample's column
    logic flush;  // final sample of the frame, report last-row flags
  } glpd_batch_t;

endpackage

`default_nettype wire

>>> hdl/glpd_ram.sv
// glpd_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle; no dependencies
`default_nettype none

module glpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/glpd_scan.sv
// glpd_scan: frame counters, line store and cross-window evaluation
// depends on glpd_pkg and glpd_ram
`default_nettype none

module glpd_scan #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_COLS    = 32,
  parameter int ROW_W       = 10,
  parameter int COL_W       = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        restart_i,
  input  logic [ROW_W-1:0]            rows_m1_i,
  input  logic [COL_W-1:0]            cols_m1_i,
  input  logic                        emit_busy_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [SAMPLE_BITS-1:0]      sample_i,
  output glpd_pkg::glpd_batch_t       batch_o,
  output logic [ROW_W-1:0]            row_o,
  output logic [COL_W-1:0]            col_o,
  output logic [MAX_COLS-1:0]         flags_o
);
  import glpd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } scan_state_e;

  localparam logic signed [SAMPLE_BITS-1:0] Zero = '0;

  function automatic logic peak(input logic signed [SAMPLE_BITS-1:0] c,
                                input logic signed [SAMPLE_BITS-1:0] l,
                                input logic signed [SAMPLE_BITS-1:0] r,
                                input logic signed [SAMPLE_BITS-1:0] u,
                                input logic signed [SAMPLE_BITS-1:0] d);
    return (c >= l) && (c >= r) && (c >= u) && (c >= d);
  endfunction

  scan_state_e st_q, st_d;
  logic [ROW_W-1:0] row_q, row_d, cur_row_q;
  logic [COL_W-1:0] col_q, col_d, cur_col_q, col_next, col_left;
  logic [MAX_COLS-1:0] flags_q, flags_d, flags_n;
  logic signed [SAMPLE_BITS-1:0] s_q, s1_q, s2_q, left_q;
  logic signed [SAMPLE_BITS-1:0] ahead_prev_q, ahead_older_q;
  logic signed [SAMPLE_BITS-1:0] rd_prev, rd_older, rt, lt, up;
  logic [2*SAMPLE_BITS-1:0] rdata;
  logic accept, last_row, last_col, above, final_smp;

  assign in_ready_o = (st_q == ST_IDLE) && !emit_busy_i;
  assign accept     = in_valid_i && in_ready_o;
  assign col_next   = (col_q == cols_m1_i) ? '0 : col_q + 1'b1;

  // entry holds {older row, previous row}
  glpd_ram #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (MAX_COLS),
    .ADDR_W(COL_W)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(col_q),
    .wdata_i({ahead_prev_q, sample_i}),
    .raddr_i(col_next),
    .rdata_o(rdata)
  );

  assign rd_prev  = signed'(rdata[SAMPLE_BITS-1:0]);
  assign rd_older = signed'(rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);

  always_comb begin
    st_d      = st_q;
    row_d     = row_q;
    col_d     = col_q;
    flags_d   = flags_q;
    last_row  = (cur_row_q == rows_m1_i);
    last_col  = (cur_col_q == cols_m1_i);
    final_smp = last_row && last_col;
    col_left  = cur_col_q - 1'b1;
    rt        = last_col ? Zero : rd_prev;
    lt        = (cur_col_q != '0) ? left_q : Zero;
    up        = (cur_row_q > ROW_W'(1)) ? ahead_older_q : Zero;
    above     = (cur_row_q != '0) && peak(ahead_prev_q, lt, rt, up, s_q);
    flags_n   = flags_q;
    if (last_row && (cur_col_q != '0) &&
        peak(s1_q, (cur_col_q > COL_W'(1)) ? s2_q : Zero, s_q,
             (cur_row_q != '0) ? left_q : Zero, Zero)) begin
      flags_n[col_left] = 1'b1;
    end
    if (final_smp &&
        peak(s_q, (cur_col_q != '0) ? s1_q : Zero, Zero,
             (cur_row_q != '0) ? ahead_prev_q : Zero, Zero)) begin
      flags_n[cur_col_q] = 1'b1;
    end

    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          st_d  = ST_EVAL;
          col_d = col_next;
          if (col_q == cols_m1_i) begin
            row_d = (row_q == rows_m1_i) ? '0 : row_q + 1'b1;
          end
        end
      end
      ST_EVAL: begin
        st_d    = ST_IDLE;
        flags_d = final_smp ? '0 : flags_n;
      end
      default: st_d = ST_IDLE;
    endcase

    if (restart_i) begin
      row_d   = '0;
      col_d   = '0;
      flags_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      flags_q <= '0;
    end else begin
      st_q    <= st_d;
      row_q   <= row_d;
      col_q   <= col_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q       <= signed'(sample_i);
      cur_row_q <= row_q;
      cur_col_q <= col_q;
    end
    if (st_q == ST_EVAL) begin
      s1_q   <= s_q;
      s2_q   <= s1_q;
      left_q <= ahead_prev_q;
      // single column: the entry just written is the next one
      if (cols_m1_i == '0) begin
        ahead_prev_q  <= s_q;
        ahead_older_q <= ahead_prev_q;
      end else begin
        ahead_prev_q  <= rd_prev;
        ahead_older_q <= rd_older;
      end
    end
  end

  assign batch_o.load  = (st_q == ST_EVAL);
  assign batch_o.above = above;
  assign batch_o.flush = final_smp;
  assign row_o         = cur_row_q;
  assign col_o         = cur_col_q;
  assign flags_o       = flags_n;

endmodule

`default_nettype wire

>>> hdl/glpd_emit.sv
// glpd_emit: result queue and output register of the peak detector
// depends on glpd_pkg
`default_nettype none

module glpd_emit #(
  parameter int MAX_COLS = 32,
  parameter int ROW_W    = 10,
  parameter int COL_W    = 5
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  glpd_pkg::glpd_batch_t                batch_i,
  input  logic [ROW_W-1:0]                     row_i,
  input  logic [COL_W-1:0]                     col_i,
  input  logic [MAX_COLS-1:0]                  flags_i,
  output logic                                 busy_o,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [glpd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tlast
);
  import glpd_pkg::*;

  logic pend_q, vld_q, last_q, slot_free, pop, res_last;
  logic [ROW_W-1:0] row_q, res_row;
  logic [COL_W-1:0] col_q, res_col, enc;
  logic [MAX_COLS-1:0] flush_q, lowest, rest;
  logic [OUT_TDATA_W-1:0] data_q;
  logic [31:0] row32, col32;

  always_comb begin
    enc = '0;
    busy_o    = pend_q || (flush_q != '0);
    slot_free = !vld_q || m_axis_tready;
    pop       = busy_o && slot_free;
    lowest    = flush_q & (~flush_q + 1'b1);
    rest      = flush_q & ~lowest;
    for (int i = 0; i < MAX_COLS; i++) begin
      if (lowest[i]) begin
        enc = enc | COL_W'(i);
      end
    end
    if (pend_q) begin
      res_row  = row_q - 1'b1;
      res_col  = col_q;
      res_last = (flush_q == '0);
    end else begin
      res_row  = row_q;
      res_col  = enc;
      res_last = (rest == '0);
    end
    row32 = 32'(res_row);
    col32 = 32'(res_col);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      pend_q  <= 1'b0;
      flush_q <= '0;
    end else begin
      if (slot_free) begin
        vld_q <= busy_o;
      end
      if (batch_i.load) begin
        pend_q  <= batch_i.above;
        flush_q <= batch_i.flush ? flags_i : '0;
      end else if (pop) begin
        if (pend_q) begin
          pend_q <= 1'b0;
        end else begin
          flush_q <= rest;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (batch_i.load) begin
      row_q <= row_i;
      col_q <= col_i;
    end
    if (pop) begin
      data_q <= {{OUT_PAD_W{1'b0}}, col32[COL_OUT_W-1:0], row32[ROW_OUT_W-1:0]};
      last_q <= res_last;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;

endmodule

`default_nettype wire

>>> hdl/grid_local_peak_detector_core.sv
// four-neighbour local maximum detector over raster-order frames:
// each sample is accepted, then evaluated against the line store read, and
// the next sample waits until the results that it reports have been moved
// into the output register; the final sample of a frame reports up to
// MAX_COLS + 1 results, one per cycle while the output is not stalled. reset
// sets a 1x1 frame and clears counters and flags; the line store needs no clearing pass.
`default_nettype none

module grid_local_peak_detector_core #(
  parameter int MAX_COLS    = 32,
  parameter int MAX_ROWS    = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [IN_TDATA_W-1:0]                s_axis_tdata,   // sample
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [glpd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // peak_col, peak_row
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_we_i,
  input  logic [glpd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [glpd_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import glpd_pkg::*;

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [ROW_W-1:0] rows_m1_q, rows_m1_d, batch_row;
  logic [COL_W-1:0] cols_m1_q, cols_m1_d, batch_col;
  logic [CFG_ROWS_W-1:0] rows_v;
  logic [CFG_COLS_W-1:0] cols_v;
  logic [MAX_COLS-1:0] batch_flags;
  logic restart, emit_busy;
  glpd_batch_t batch;

  // register writes, out-of-range values clamped to the frame limits
  always_comb begin
    rows_m1_d = rows_m1_q;
    cols_m1_d = cols_m1_q;
    restart   = 1'b0;
    rows_v    = cfg_data_i[CFG_ROWS_W-1:0];
    cols_v    = cfg_data_i[CFG_COLS_W-1:0];
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_ROWS: begin
          restart = 1'b1;
          if (rows_v == '0) begin
            rows_m1_d = '0;
          end else if (32'(rows_v) > MAX_ROWS) begin
            rows_m1_d = ROW_W'(MAX_ROWS - 1);
          end else begin
            rows_m1_d = ROW_W'(rows_v - 1'b1);
          end
        end
        REG_FRAME_COLS: begin
          restart = 1'b1;
          if (cols_v == '0) begin
            cols_m1_d = '0;
          end else if (32'(cols_v) > MAX_COLS) begin
            cols_m1_d = COL_W'(MAX_COLS - 1);
          end else begin
            cols_m1_d = COL_W'(cols_v - 1'b1);
          end
        end
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_m1_q <= '0;
      cols_m1_q <= '0;
    end else begin
      rows_m1_q <= rows_m1_d;
      cols_m1_q <= cols_m1_d;
    end
  end

  glpd_scan #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_COLS   (MAX_COLS),
    .ROW_W      (ROW_W),
    .COL_W      (COL_W)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (restart),
    .rows_m1_i  (rows_m1_q),
    .cols_m1_i  (cols_m1_q),
    .emit_busy_i(emit_busy),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sample_i   (s_axis_tdata[SAMPLE_BITS-1:0]),
    .batch_o    (batch),
    .row_o      (batch_row),
    .col_o      (batch_col),
    .flags_o    (batch_flags)
  );

  glpd_emit #(
    .MAX_COLS(MAX_COLS),
    .ROW_W   (ROW_W),
    .COL_W   (COL_W)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .batch_i      (batch),
    .row_i        (batch_row),
    .col_i        (batch_col),
    .flags_i      (batch_flags),
    .busy_o       (emit_busy),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

`default_nettype wire
